// File: rtl/wgc_pkg.sv
// Package of the waypoint go-to controller: constants, codes and the
// arctangent table of the vectoring unit. Depends on nothing.
package wgc_pkg;

  localparam int unsigned ATAN_N = 24;
  localparam int unsigned XW = 28;

  localparam logic [1:0] CMD_PUSH       = 2'd0;
  localparam logic [1:0] CMD_CLEAR      = 2'd1;
  localparam logic [1:0] CMD_SAMPLE     = 2'd2;
  localparam logic [1:0] CMD_SAMPLE_ALT = 2'd3;

  localparam logic [2:0] ST_TRACK    = 3'd0;
  localparam logic [2:0] ST_REACHED  = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_NO_WP    = 3'd3;
  localparam logic [2:0] ST_LOADED   = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [2:0] REG_TOL      = 3'd0;
  localparam logic [2:0] REG_FWD_STEP = 3'd1;
  localparam logic [2:0] REG_FWD_LIM  = 3'd2;
  localparam logic [2:0] REG_ROT_GAIN = 3'd3;
  localparam logic [2:0] REG_ROT_STEP = 3'd4;
  localparam logic [2:0] REG_ROT_LIM  = 3'd5;
  localparam logic [2:0] REG_TURN     = 3'd6;

  localparam logic [9:0]  RST_TOL      = 10'd30;
  localparam logic [7:0]  RST_FWD_STEP = 8'd5;
  localparam logic [9:0]  RST_FWD_LIM  = 10'd750;
  localparam logic [3:0]  RST_ROT_GAIN = 4'd5;
  localparam logic [11:0] RST_ROT_STEP = 12'd402;
  localparam logic [12:0] RST_ROT_LIM  = 13'd6434;
  localparam logic [12:0] RST_TURN     = 13'd1072;

  localparam logic signed [16:0] INV_GAIN_Q16  = 17'sd39797;
  localparam logic signed [16:0] PI_OVER_8_Q16 = 17'sd25736;

  typedef logic [23:0] angle_t;

  function automatic angle_t wgc_atan(logic [4:0] idx);
    angle_t a;
    a = '0;
    unique case (idx)
      5'd0:  a = 24'd2097152;
      5'd1:  a = 24'd1238021;
      5'd2:  a = 24'd654136;
      5'd3:  a = 24'd332050;
      5'd4:  a = 24'd166669;
      5'd5:  a = 24'd83416;
      5'd6:  a = 24'd41718;
      5'd7:  a = 24'd20860;
      5'd8:  a = 24'd10430;
      5'd9:  a = 24'd5215;
      5'd10: a = 24'd2608;
      5'd11: a = 24'd1304;
      5'd12: a = 24'd652;
      5'd13: a = 24'd326;
      5'd14: a = 24'd163;
      5'd15: a = 24'd81;
      5'd16: a = 24'd41;
      5'd17: a = 24'd20;
      5'd18: a = 24'd10;
      5'd19: a = 24'd5;
      5'd20: a = 24'd3;
      5'd21: a = 24'd1;
      5'd22: a = 24'd1;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/wgc_in_if.sv
// Input channel of the waypoint go-to controller.
// Carries one command word with its position and heading.
interface wgc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        heading;

  modport source (output valid, command, pos_x, pos_y, heading, input ready);
  modport sink (input valid, command, pos_x, pos_y, heading, output ready);
endinterface

// File: rtl/wgc_out_if.sv
// Output channel of the waypoint go-to controller.
// Carries one drive command word per input word.
interface wgc_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         forward_speed;
  logic signed [13:0] rotation_speed;
  logic               stop_lidar;
  logic               halt_drive;
  logic [2:0]         status;

  modport source (output valid, forward_speed, rotation_speed, stop_lidar, halt_drive,
                  status, input ready);
  modport sink (input valid, forward_speed, rotation_speed, stop_lidar, halt_drive,
                status, output ready);
endinterface

// File: rtl/waypoint_goto_controller.sv
// Waypoint go-to controller, top level. Depends on wgc_pkg, wgc_in_if,
// wgc_out_if, wgc_ram and wgc_cordic.
//
// Words arrive on in_i and each gives exactly one word on out_o, in order.
// A push, a clear or a sample on an empty stack goes from S_IDLE straight to
// S_DONE, and a sample that reaches its waypoint passes through S_READ.
// Any other odometry sample also runs S_CORDIC, in which the CORDIC unit
// performs one micro-rotation per cycle, then S_MAG, S_GAIN, S_SCALE and
// S_UPDATE; ready stays low while a word is in work. The result word becomes
// valid in the same cycle that ready returns. The finished word sits in an
// output register; the next input word is taken while it waits, and the
// block holds its last step until the receiver takes the previous word.
// Write the registers over the APB-style port at byte address 4*index only
// while the block is idle; the block itself does not enforce this.
// Reset empties the waypoint stack, zeroes the speeds and flags and loads
// the register defaults. The stack memory needs no clearing pass.
module waypoint_goto_controller
  import wgc_pkg::*;
#(
  parameter int unsigned PATH_DEPTH   = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wgc_in_if.sink      in_i,
  wgc_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PATH_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_CORDIC = 3'd2;
  localparam logic [2:0] S_MAG    = 3'd3;
  localparam logic [2:0] S_GAIN   = 3'd4;
  localparam logic [2:0] S_SCALE  = 3'd5;
  localparam logic [2:0] S_UPDATE = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [9:0]  tol_q, fwd_lim_q;
  logic [7:0]  fwd_step_q;
  logic [3:0]  gain_q;
  logic [11:0] rot_step_q;
  logic [12:0] rot_lim_q, turn_q;

  logic [2:0]         state_q;
  logic [CW-1:0]      count_q;
  logic               fin_q, lidar_q;
  logic [9:0]         fwd_q;
  logic signed [13:0] rot_q;
  logic               halt_q;
  logic [2:0]         status_q;
  logic signed [15:0] px_q, py_q;
  logic [15:0]        head_q;
  logic               zero_q;
  logic [17:0]        dist_q;
  logic signed [15:0] err_q;
  logic signed [20:0] ge_q;
  logic signed [19:0] req_q;

  logic               out_valid_q, out_lidar_q, out_halt_q;
  logic [9:0]         out_fwd_q;
  logic signed [13:0] out_rot_q;
  logic [2:0]         out_status_q;

  logic               accept, cfg_wr, ram_we, ram_re, arrive, cord_start, cord_done, out_free;
  logic [31:0]        ram_rdata;
  logic [AW-1:0]      ram_raddr;
  logic signed [16:0] dx, dy;
  logic [16:0]        adx, ady;
  logic signed [XW-1:0] cord_x;
  angle_t             cord_z;
  logic signed [44:0] mag_prod;
  logic [24:0]        z_round;
  logic signed [36:0] req_prod;
  logic signed [20:0] fdiff, fnext, rdiff, rnext, rlim, rstep;
  logic [13:0]        rabs;

  assign accept   = in_i.valid && in_i.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign ram_we    = accept && (in_i.command == CMD_PUSH) && (count_q < DEPTH_C);
  assign ram_re    = accept && in_i.command[1];
  assign ram_raddr = AW'(count_q - CW'(1));

  wgc_ram #(
    .WIDTH(32),
    .DEPTH(PATH_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({in_i.pos_x, in_i.pos_y}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign dx  = 17'(signed'(ram_rdata[31:16])) - 17'(px_q);
  assign dy  = 17'(signed'(ram_rdata[15:0])) - 17'(py_q);
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign arrive = (adx < 17'(tol_q)) && (ady < 17'(tol_q));
  assign cord_start = (state_q == S_READ) && !arrive;

  wgc_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start),
    .dx_i   (dx),
    .dy_i   (dy),
    .done_o (cord_done),
    .x_o    (cord_x),
    .z_o    (cord_z)
  );

  assign mag_prod = 45'(cord_x) * 45'(INV_GAIN_Q16) + 45'sd8388608;
  assign z_round  = {1'b0, cord_z} + 25'd128;
  assign req_prod = 37'(ge_q) * 37'(PI_OVER_8_Q16) + 37'sd32768;

  assign fdiff = 21'(signed'({1'b0, dist_q})) - 21'(signed'({1'b0, fwd_q}));
  assign fnext = (fdiff > 21'(signed'({1'b0, fwd_step_q})))
               ? 21'(signed'({1'b0, fwd_q})) + 21'(signed'({1'b0, fwd_step_q}))
               : 21'(signed'({1'b0, dist_q}));

  assign rstep = 21'(signed'({1'b0, rot_step_q}));
  assign rlim  = 21'(signed'({1'b0, rot_lim_q}));
  assign rdiff = 21'(rot_q) - 21'(req_q);

  always_comb begin
    priority if (rdiff > rstep) begin
      rnext = 21'(rot_q) - rstep;
    end else if (rdiff < -rstep) begin
      rnext = 21'(rot_q) + rstep;
    end else begin
      rnext = 21'(req_q);
    end
    if (rnext > rlim) begin
      rnext = rlim;
    end
    if (rnext < -rlim) begin
      rnext = -rlim;
    end
  end

  assign rabs = rnext[20] ? 14'(-rnext) : 14'(rnext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= RST_TOL;
      fwd_step_q <= RST_FWD_STEP;
      fwd_lim_q  <= RST_FWD_LIM;
      gain_q     <= RST_ROT_GAIN;
      rot_step_q <= RST_ROT_STEP;
      rot_lim_q  <= RST_ROT_LIM;
      turn_q     <= RST_TURN;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TOL:      tol_q      <= pwdata[9:0];
        REG_FWD_STEP: fwd_step_q <= pwdata[7:0];
        REG_FWD_LIM:  fwd_lim_q  <= pwdata[9:0];
        REG_ROT_GAIN: gain_q     <= pwdata[3:0];
        REG_ROT_STEP: rot_step_q <= pwdata[11:0];
        REG_ROT_LIM:  rot_lim_q  <= pwdata[12:0];
        REG_TURN:     turn_q     <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TOL:      prdata = 32'(tol_q);
      REG_FWD_STEP: prdata = 32'(fwd_step_q);
      REG_FWD_LIM:  prdata = 32'(fwd_lim_q);
      REG_ROT_GAIN: prdata = 32'(gain_q);
      REG_ROT_STEP: prdata = 32'(rot_step_q);
      REG_ROT_LIM:  prdata = 32'(rot_lim_q);
      REG_TURN:     prdata = 32'(turn_q);
      default:      prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      fin_q       <= 1'b0;
      lidar_q     <= 1'b0;
      fwd_q       <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_i.command == CMD_PUSH) begin
              state_q <= S_DONE;
              if (count_q < DEPTH_C) begin
                count_q <= count_q + CW'(1);
                fin_q   <= 1'b0;
              end
            end else if (in_i.command == CMD_CLEAR) begin
              state_q <= S_DONE;
              count_q <= '0;
              fin_q   <= 1'b0;
            end else if (count_q != '0) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_READ: begin
          if (arrive) begin
            state_q <= S_DONE;
            if (count_q > CW'(1)) begin
              count_q <= count_q - CW'(1);
            end else begin
              fin_q <= 1'b1;
            end
          end else begin
            state_q <= S_CORDIC;
          end
        end
        S_CORDIC: if (cord_done) state_q <= S_MAG;
        S_MAG:    state_q <= S_GAIN;
        S_GAIN:   state_q <= S_SCALE;
        S_SCALE:  state_q <= S_UPDATE;
        S_UPDATE: begin
          fwd_q   <= (fnext > 21'(signed'({1'b0, fwd_lim_q}))) ? fwd_lim_q : fnext[9:0];
          rot_q   <= rnext[13:0];
          lidar_q <= (rabs >= 14'(turn_q));
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= in_i.pos_x;
      py_q   <= in_i.pos_y;
      head_q <= in_i.heading;
      halt_q <= in_i.command[1];
      if (in_i.command == CMD_PUSH) begin
        status_q <= (count_q < DEPTH_C) ? ST_LOADED : ST_FULL;
      end else if (in_i.command == CMD_CLEAR) begin
        status_q <= ST_LOADED;
      end else begin
        status_q <= ST_NO_WP;
      end
    end
    if (state_q == S_READ) begin
      zero_q <= (dx == '0) && (dy == '0);
      if (arrive) begin
        status_q <= (count_q > CW'(1)) ? ST_REACHED : ST_FINISHED;
      end else begin
        status_q <= ST_TRACK;
        halt_q   <= 1'b0;
      end
    end
    if (state_q == S_MAG) begin
      dist_q <= mag_prod[41:24];
      err_q  <= signed'((zero_q ? 16'd0 : z_round[23:8]) - head_q);
    end
    if (state_q == S_GAIN) begin
      ge_q <= 21'(signed'({1'b0, gain_q})) * 21'(err_q);
    end
    if (state_q == S_SCALE) begin
      req_q <= req_prod[35:16];
    end
    if (state_q == S_DONE && out_free) begin
      out_fwd_q    <= (state_q == S_DONE) ? fwd_q : '0;
      out_rot_q    <= rot_q;
      out_lidar_q  <= lidar_q;
      out_halt_q   <= halt_q;
      out_status_q <= status_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.forward_speed  = out_fwd_q;
  assign out_o.rotation_speed = out_rot_q;
  assign out_o.stop_lidar     = out_lidar_q;
  assign out_o.halt_drive     = out_halt_q;
  assign out_o.status         = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C) else $error("waypoint count beyond stack depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_i.ready) else $error("input taken while a word is in work");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q) else $error("result word lost");

  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == S_CORDIC) else $error("vectoring result outside its step");

endmodule

// File: rtl/wgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module wgc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/wgc_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle on one
// shared shifter and adder set. Depends on wgc_pkg.
module wgc_cordic
  import wgc_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [16:0]   dx_i,
  input  logic signed [16:0]   dy_i,
  output logic                 done_o,
  output logic signed [XW-1:0] x_o,
  output angle_t               z_o
);

  localparam int unsigned N = (STEPS < ATAN_N) ? STEPS : ATAN_N;
  localparam logic [4:0] LAST = 5'(N - 1);

  logic                 busy_q, done_q;
  logic [4:0]           i_q;
  logic signed [XW-1:0] x_q, y_q, xs, ys, x0, y0;
  angle_t               z_q, atan;

  assign x0 = {{(XW-25){dx_i[16]}}, dx_i, 8'd0};
  assign y0 = {{(XW-25){dy_i[16]}}, dy_i, 8'd0};
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign atan = wgc_atan(i_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (dx_i[16]) begin
        x_q <= -x0;
        y_q <= -y0;
        z_q <= 24'h800000;
      end else begin
        x_q <= x0;
        y_q <= y0;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (!y_q[XW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule

// File: tb/tb_waypoint_goto_controller.sv
// Testbench of the waypoint go-to controller: drives words through the
// input channel, predicts each drive command word and checks it in order.
// Depends on wgc_pkg, wgc_in_if, wgc_out_if and the controller RTL.
`timescale 1ns / 100ps

class drive_scoreboard;
  typedef struct packed {
    logic [9:0]         fwd;
    logic signed [13:0] rot;
    logic               lidar;
    logic               halt;
    logic [2:0]         status;
  } drive_word_t;

  logic [31:0]  waypoints[16];
  int unsigned  wp_count;
  longint       fwd_now, rot_now;
  bit           lidar_flag, finished;
  longint       tol, fwd_step, fwd_lim, gain, rot_step, rot_lim, turn_thr;
  drive_word_t  pending[$];
  int unsigned  mismatches, checked;

  function void reset_state();
    wp_count = 0; fwd_now = 0; rot_now = 0; lidar_flag = 0; finished = 0;
    tol = 30; fwd_step = 5; fwd_lim = 750; gain = 5; rot_step = 402;
    rot_lim = 6434; turn_thr = 1072;
  endfunction

  function void set_reg(int idx, longint val);
    case (idx)
      wgc_pkg::REG_TOL:      tol = val & 'h3ff;
      wgc_pkg::REG_FWD_STEP: fwd_step = val & 'hff;
      wgc_pkg::REG_FWD_LIM:  fwd_lim = val & 'h3ff;
      wgc_pkg::REG_ROT_GAIN: gain = val & 'hf;
      wgc_pkg::REG_ROT_STEP: rot_step = val & 'hfff;
      wgc_pkg::REG_ROT_LIM:  rot_lim = val & 'h1fff;
      wgc_pkg::REG_TURN:     turn_thr = val & 'h1fff;
      default: ;
    endcase
  endfunction

  static function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function void push_result(bit halt, logic [2:0] st);
    drive_word_t w;
    w.fwd = fwd_now[9:0];
    w.rot = rot_now[13:0];
    w.lidar = lidar_flag;
    w.halt = halt;
    w.status = st;
    pending.insert(pending.size(), w);
  endfunction

  function void note_command(logic [1:0] cmd, logic signed [15:0] px,
                             logic signed [15:0] py, logic [15:0] hdg);
    longint dx, dy, x, y, mag, err, req, diff, xs, ys;
    logic [23:0] z;
    logic [15:0] bearing, e16;
    if (cmd == wgc_pkg::CMD_PUSH) begin
      if (wp_count >= 16) begin
        push_result(0, wgc_pkg::ST_FULL);
      end else begin
        waypoints[wp_count] = {px, py};
        wp_count++;
        finished = 0;
        push_result(0, wgc_pkg::ST_LOADED);
      end
      return;
    end
    if (cmd == wgc_pkg::CMD_CLEAR) begin
      wp_count = 0;
      finished = 0;
      push_result(0, wgc_pkg::ST_LOADED);
      return;
    end
    if (wp_count == 0) begin
      push_result(1, wgc_pkg::ST_NO_WP);
      return;
    end
    dx = longint'($signed(waypoints[wp_count-1][31:16])) - longint'(px);
    dy = longint'($signed(waypoints[wp_count-1][15:0])) - longint'(py);
    if ((dx < 0 ? -dx : dx) < tol && (dy < 0 ? -dy : dy) < tol) begin
      if (wp_count > 1) begin
        wp_count--;
        push_result(1, wgc_pkg::ST_REACHED);
      end else begin
        finished = 1;
        push_result(1, wgc_pkg::ST_FINISHED);
      end
      return;
    end
    if (dx == 0 && dy == 0) begin
      mag = 0;
      bearing = 0;
    end else begin
      x = dx * 256; y = dy * 256; z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 24'h800000;
      end
      for (int i = 0; i < 16; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += wgc_pkg::wgc_atan(5'(i));
        end else begin
          x -= ys; y += xs; z -= wgc_pkg::wgc_atan(5'(i));
        end
      end
      bearing = 16'((32'(z) + 128) >> 8);
      mag = (x * 39797 + (longint'(1) << 23)) >>> 24;
    end
    e16 = bearing - hdg;
    err = longint'($signed(e16));
    if (mag - fwd_now > fwd_step) fwd_now += fwd_step;
    else fwd_now = mag;
    if (fwd_now > fwd_lim) fwd_now = fwd_lim;
    req = floor_shift(gain * err * 25736 + 32768, 16);
    diff = rot_now - req;
    if (diff > rot_step) rot_now -= rot_step;
    else if (diff < -rot_step) rot_now += rot_step;
    else rot_now = req;
    if (rot_now > rot_lim) rot_now = rot_lim;
    if (rot_now < -rot_lim) rot_now = -rot_lim;
    lidar_flag = (rot_now < 0 ? -rot_now : rot_now) >= turn_thr;
    push_result(0, wgc_pkg::ST_TRACK);
  endfunction

  function void check_word(drive_word_t got);
    drive_word_t exp_w;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected word %p", got);
      return;
    end
    exp_w = pending.pop_front();
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Mismatch: expected fwd %0d rot %0d lidar %0d halt %0d st %0d,",
                  " got %0d %0d %0d %0d %0d"},
                 exp_w.fwd, exp_w.rot, exp_w.lidar, exp_w.halt, exp_w.status,
                 got.fwd, got.rot, got.lidar, got.halt, got.status);
    end
  endfunction
endclass

module tb_waypoint_goto_controller;
  import wgc_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wgc_in_if  in_ch();
  wgc_out_if out_ch();

  waypoint_goto_controller uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  drive_scoreboard board = new();
  int unsigned send_idle_pct, recv_idle_pct;
  bit          hold_off;
  longint      cycles = 0;
  int unsigned words_sent, samples_sent;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      board.check_word({out_ch.forward_speed, out_ch.rotation_speed, out_ch.stop_lidar,
                        out_ch.halt_drive, out_ch.status});
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_word(logic [1:0] cmd, logic [15:0] px, logic [15:0] py,
                           logic [15:0] hdg);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1; in_ch.command <= cmd; in_ch.pos_x <= px;
    in_ch.pos_y <= py; in_ch.heading <= hdg;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    board.note_command(cmd, px, py, hdg);
    words_sent++;
    if (cmd[1]) samples_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, val);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_ch.valid <= 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_path(int unsigned n);
    logic signed [15:0] wx, wy, rx, ry;
    int unsigned k;
    k = 0;
    while (k < n) begin
      case ($urandom_range(19))
        0: begin
          send_word(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom)); k++;
        end
        1: begin
          send_word(CMD_SAMPLE_ALT, 16'($urandom), 16'($urandom), 16'($urandom)); k++;
        end
        2, 3, 4: begin
          send_word(CMD_PUSH, 16'($urandom), 16'($urandom), 16'($urandom)); k++;
        end
        default: begin
          wx = 16'($urandom); wy = 16'($urandom);
          send_word(CMD_PUSH, wx, wy, 16'($urandom)); k++;
          repeat ($urandom_range(6, 1)) begin
            if ($urandom_range(3) == 0) begin
              rx = wx + $signed(16'($urandom_range(60))) - 16'sd30;
              ry = wy + $signed(16'($urandom_range(60))) - 16'sd30;
            end else if ($urandom_range(1)) begin
              rx = wx + $signed(16'($urandom_range(4000))) - 16'sd2000;
              ry = wy + $signed(16'($urandom_range(4000))) - 16'sd2000;
            end else begin
              rx = 16'($urandom); ry = 16'($urandom);
            end
            send_word(CMD_SAMPLE, rx, ry, 16'($urandom)); k++;
          end
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 0; in_ch.command = '0; in_ch.pos_x = '0; in_ch.pos_y = '0;
    in_ch.heading = '0;
    hold_off = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    board.reset_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty stack, extremes, full stack, arrival, finish, zero error.
    send_word(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    send_word(CMD_PUSH, 16'h7fff, 16'h7fff, 16'hffff);
    send_word(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h0000);
    send_word(CMD_SAMPLE_ALT, 16'h8000, 16'h8000, 16'h8000);
    send_word(CMD_SAMPLE, 16'h7fff, 16'h7ff0, 16'h1234);
    for (int i = 0; i < 16; i++) send_word(CMD_PUSH, 16'(i * 100), 16'(-i * 50), 16'h0);
    send_word(CMD_SAMPLE, 16'd1500, -16'sd750, 16'hffff);
    send_word(CMD_CLEAR, 16'hffff, 16'hffff, 16'hffff);
    drain();
    write_reg(REG_TOL, 0);
    send_word(CMD_PUSH, 16'd5, 16'd5, 16'd0);
    send_word(CMD_SAMPLE, 16'd5, 16'd5, 16'd0);
    send_word(CMD_SAMPLE, 16'd5, 16'd4, 16'h4000);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 15 : ph == 1 ? 68 : 0;
      recv_idle_pct = ph == 0 ? 68 : ph == 1 ? 15 : 0;
      write_reg(REG_TOL, ph == 0 ? 1023 : ph == 1 ? $urandom_range(80) : 0);
      write_reg(REG_FWD_STEP, ph == 0 ? 255 : ph == 1 ? 0 : $urandom_range(255));
      write_reg(REG_FWD_LIM, ph == 0 ? 1023 : ph == 1 ? 0 : $urandom_range(1023));
      write_reg(REG_ROT_GAIN, ph == 0 ? 15 : ph == 1 ? 0 : $urandom_range(15));
      write_reg(REG_ROT_STEP, ph == 0 ? 4095 : ph == 1 ? 0 : $urandom_range(4095));
      write_reg(REG_ROT_LIM, ph == 0 ? 8191 : ph == 1 ? 0 : $urandom_range(8191));
      write_reg(REG_TURN, ph == 0 ? 0 : ph == 1 ? 8191 : $urandom_range(8191));
      if (ph == 2) begin
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk_i);
            hold_off = 0;
          end
          begin
            random_path(40);
            in_ch.valid <= 0;
            @(posedge clk_i);
          end
        join
      end
      random_path(ph == 1 ? 150 : ph == 2 ? 300 : 400);
      drain();
      write_reg(REG_TOL, 30);
      write_reg(REG_FWD_STEP, 5);
      write_reg(REG_FWD_LIM, 750);
      write_reg(REG_ROT_GAIN, 5);
      write_reg(REG_ROT_STEP, 402);
      write_reg(REG_ROT_LIM, 6434);
      write_reg(REG_TURN, 1072);
      random_path(ph == 1 ? 30 : 60);
      drain();
    end

    $display("Sent %0d words, %0d odometry samples; checked %0d drive words.",
             words_sent, samples_sent, board.checked);
    $display("Covered register extremes, a full stack, arrivals and long stalls.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d words missing", board.mismatches,
               board.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
